// ----- design/pcir_pkg.sv -----
// pcir_pkg: shared constants and types for the particle contact impulse resolve core
// no dependencies; imported by every module of the core

package pcir_pkg;

    localparam int NORM_W      = 16;   // one normal component, signed Q1.14
    localparam int IMASS_W     = 16;   // inverse mass, unsigned Q8.8
    localparam int TIM_W       = 17;   // sum of two inverse masses
    localparam int PEN_W       = 16;   // penetration, signed Q8.8
    localparam int PEN_MAG_W   = 15;   // positive penetration magnitude
    localparam int REST_W      = 9;    // restitution, unsigned Q1.8
    localparam int TSTEP_W     = 16;   // time step, unsigned Q0.16
    localparam int SV_SHIFT    = 6;    // dot product to separating velocity
    localparam int REST_SHIFT  = 8;    // restitution product scaling
    localparam int ACC_SHIFT   = 22;   // acceleration term scaling
    localparam int VEL_SHIFT   = 22;   // velocity share times normal
    localparam int POS_BASE    = 30;   // position shift is this minus fraction bits

    localparam logic [TSTEP_W-1:0] TSTEP_RESET = 16'd1092;

    // register map, byte address bit 2 selects the register
    localparam logic REG_TIME_STEP = 1'b0;

    typedef struct packed {
        logic has_other;   // second particle present
        logic mass_nz;     // total inverse mass nonzero
        logic pen_pos;     // penetration above zero
    } pcir_flags_t;

endpackage

// ----- design/particle_contact_impulse_resolve_core.sv -----
// particle_contact_impulse_resolve_core: top level, stream ports, register port, queue
// depends on pcir_pkg, pcir_front, pcir_fifo, pcir_back (which uses pcir_div)
//
//   channel   direction  handshake          contents
//   s_*       in         tvalid / tready    one contact per transaction
//   m_*       out        tvalid / tready    one resolved contact per transaction
//   apb       in         psel/penable       time_step register at byte address 0
//
// one contact per clock sustained while m_tready does not hold the output; an accepted
// contact is written into the queue, then passes the back stages, most of them the
// COMPONENT_WIDTH + 17 stage one-bit-per-stage dividers
// the front classifies combinationally into a four-entry queue; the back pipeline
// moves only when its output register is empty or being taken, bubbles flow through
// reset clears valid bits, queue pointers and loads time_step with 1092

module particle_contact_impulse_resolve_core #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 8,
    localparam int IN_W  = ((18*COMPONENT_WIDTH + 105 + 7) / 8) * 8,
    localparam int OUT_W = ((12*COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // main_velocity, other_velocity, main_acceleration, other_acceleration,
    // main_position, other_position, main_inverse_mass, other_inverse_mass,
    // contact normal, penetration, restitution, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    // has_other
    input  logic [0:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // main_velocity_out, other_velocity_out, main_position_out, other_position_out
    output logic [OUT_W-1:0] m_tdata,
    // velocity_applied, position_applied
    output logic [1:0]       m_tuser,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pcir_pkg::*;

    localparam int W       = COMPONENT_WIDTH;
    localparam int Q_DEPTH = 4;
    localparam int OFF_OV  = 3*W;
    localparam int OFF_MA  = 6*W;
    localparam int OFF_OA  = 9*W;
    localparam int OFF_MP  = 12*W;
    localparam int OFF_OP  = 15*W;
    localparam int OFF_IMM = 18*W;
    localparam int OFF_IMO = OFF_IMM + IMASS_W;
    localparam int OFF_N   = OFF_IMO + IMASS_W;
    localparam int OFF_PEN = OFF_N + 3*NORM_W;
    localparam int OFF_R   = OFF_PEN + PEN_W;

    typedef struct packed {
        logic [3*W-1:0]       mv;
        logic [3*W-1:0]       ov;
        logic [3*W-1:0]       mp;
        logic [3*W-1:0]       op;
        logic [3*NORM_W-1:0]  normal;
        logic [REST_W-1:0]    rest;
        logic [IMASS_W-1:0]   imm;
        logic [IMASS_W-1:0]   imo;
        logic [TIM_W-1:0]     tim;
        logic [PEN_MAG_W-1:0] pen;
        logic [3*(W+1)-1:0]   rv;
        logic [3*(W+1)-1:0]   ra;
        pcir_flags_t          flags;
    } item_t;

    localparam int ITEM_W = $bits(item_t);
    localparam int CNT_W  = $clog2(Q_DEPTH+1);

    // configuration register
    logic [TSTEP_W-1:0] time_step_reg, time_step_next;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TIME_STEP);
    assign prdata    = (paddr[2] == REG_TIME_STEP) ? {16'd0, time_step_reg} : '0;

    always_comb
    begin
        time_step_next = time_step_reg;
        if (cfg_write)
        begin
            time_step_next = pwdata[TSTEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TSTEP_RESET;
        end
        else
        begin
            time_step_reg <= time_step_next;
        end
    end

    // front: classify straight into the queue
    item_t              q_in;
    item_t              q_out;
    logic [ITEM_W-1:0]  q_data;
    logic               q_valid;
    logic               q_pop;
    logic [CNT_W-1:0]   q_count;
    logic               back_ready;

    assign q_in.mv     = s_tdata[0 +: 3*W];
    assign q_in.ov     = s_tdata[OFF_OV +: 3*W];
    assign q_in.mp     = s_tdata[OFF_MP +: 3*W];
    assign q_in.op     = s_tdata[OFF_OP +: 3*W];
    assign q_in.normal = s_tdata[OFF_N +: 3*NORM_W];
    assign q_in.rest   = s_tdata[OFF_R +: REST_W];
    assign q_in.imm    = s_tdata[OFF_IMM +: IMASS_W];

    pcir_front #(.W(W)) u_front
    (
        .main_velocity      (s_tdata[0 +: 3*W]),
        .other_velocity     (s_tdata[OFF_OV +: 3*W]),
        .main_acceleration  (s_tdata[OFF_MA +: 3*W]),
        .other_acceleration (s_tdata[OFF_OA +: 3*W]),
        .main_inverse_mass  (s_tdata[OFF_IMM +: IMASS_W]),
        .other_inverse_mass (s_tdata[OFF_IMO +: IMASS_W]),
        .penetration        (s_tdata[OFF_PEN +: PEN_W]),
        .has_other          (s_tuser[0]),
        .rel_velocity       (q_in.rv),
        .rel_acceleration   (q_in.ra),
        .other_mass         (q_in.imo),
        .total_mass         (q_in.tim),
        .pen_mag            (q_in.pen),
        .flags              (q_in.flags)
    );

    pcir_fifo #(.WIDTH(ITEM_W), .DEPTH(Q_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (back_ready),
        .pop_data   (q_data),
        .count      (q_count)
    );

    assign q_out = item_t'(q_data);
    assign q_pop = q_valid && back_ready;

    // back: resolving pipeline with its own output register
    logic [3*W-1:0] mvo, ovo, mpo, opo;

    pcir_back #(.W(W), .F(FRACTION_BITS)) u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (q_valid),
        .in_ready           (back_ready),
        .time_step          (time_step_reg),
        .rel_velocity       (q_out.rv),
        .rel_acceleration   (q_out.ra),
        .normal_vec         (q_out.normal),
        .restitution        (q_out.rest),
        .main_inverse_mass  (q_out.imm),
        .other_mass         (q_out.imo),
        .total_mass         (q_out.tim),
        .pen_mag            (q_out.pen),
        .flags              (q_out.flags),
        .main_velocity      (q_out.mv),
        .other_velocity     (q_out.ov),
        .main_position      (q_out.mp),
        .other_position     (q_out.op),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .main_velocity_out  (mvo),
        .other_velocity_out (ovo),
        .main_position_out  (mpo),
        .other_position_out (opo),
        .velocity_applied   (m_tuser[0]),
        .position_applied   (m_tuser[1])
    );

    assign m_tdata = OUT_W'({opo, mpo, ovo, mvo});

    // a stalled output must freeze the back end, so nothing leaves the queue
    a_no_pop_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue popped while output stalled");

    // an accepted contact is held in the queue on the next cycle
    a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (q_count != '0))
        else $error("accepted contact missing from queue");

    // back end takes a queued contact whenever it advances
    a_back_takes : assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && (!m_tvalid || m_tready)) |-> q_pop)
        else $error("back end idle with queued contact");

endmodule

// ----- design/pcir_front.sv -----
// pcir_front: classifies an incoming contact, forms relative terms and masses
// depends on pcir_pkg

module pcir_front #(
    parameter int W = 16
) (
    input  logic [3*W-1:0]                     main_velocity,
    input  logic [3*W-1:0]                     other_velocity,
    input  logic [3*W-1:0]                     main_acceleration,
    input  logic [3*W-1:0]                     other_acceleration,
    input  logic [pcir_pkg::IMASS_W-1:0]       main_inverse_mass,
    input  logic [pcir_pkg::IMASS_W-1:0]       other_inverse_mass,
    input  logic [pcir_pkg::PEN_W-1:0]         penetration,
    input  logic                               has_other,
    output logic [3*(W+1)-1:0]                 rel_velocity,
    output logic [3*(W+1)-1:0]                 rel_acceleration,
    output logic [pcir_pkg::IMASS_W-1:0]       other_mass,
    output logic [pcir_pkg::TIM_W-1:0]         total_mass,
    output logic [pcir_pkg::PEN_MAG_W-1:0]     pen_mag,
    output pcir_pkg::pcir_flags_t              flags
);
    import pcir_pkg::*;

    // relative terms, second particle counts as zero when absent
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rel_velocity[i*(W+1) +: (W+1)] =
                {main_velocity[i*W+W-1], main_velocity[i*W +: W]}
                - (has_other ? {other_velocity[i*W+W-1], other_velocity[i*W +: W]}
                             : {(W+1){1'b0}});
            rel_acceleration[i*(W+1) +: (W+1)] =
                {main_acceleration[i*W+W-1], main_acceleration[i*W +: W]}
                - (has_other ? {other_acceleration[i*W+W-1], other_acceleration[i*W +: W]}
                             : {(W+1){1'b0}});
        end
    end

    assign other_mass      = has_other ? other_inverse_mass : '0;
    assign total_mass      = {1'b0, main_inverse_mass} + {1'b0, other_mass};
    assign flags.has_other = has_other;
    assign flags.mass_nz   = (total_mass != '0);
    assign flags.pen_pos   = !penetration[PEN_W-1] && (penetration != '0);
    assign pen_mag         = flags.pen_pos ? penetration[PEN_MAG_W-1:0] : '0;

endmodule

// ----- design/pcir_fifo.sv -----
// pcir_fifo: short queue between the classifying front and the resolving back
// depends on pcir_pkg

module pcir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import pcir_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/pcir_div.sv -----
// pcir_div: pipelined restoring divider, one quotient bit per stage
// depends on pcir_pkg; quotient must fit QW bits (dividend < divisor * 2**QW)

module pcir_div #(
    parameter int QW = 33
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [QW+pcir_pkg::TIM_W-1:0]  dividend,
    input  logic [pcir_pkg::TIM_W-1:0]     divisor,
    output logic [QW-1:0]                  quotient
);
    import pcir_pkg::*;

    logic [TIM_W-1:0] rem_reg  [QW];
    logic [QW-1:0]    work_reg [QW];
    logic [TIM_W-1:0] div_reg  [QW-1];

    genvar k;
    for (k = 0; k < QW; k++)
    begin : g_stage
        logic [TIM_W-1:0] rem_in;
        logic [QW-1:0]    work_in;
        logic [TIM_W-1:0] div_in;
        logic [TIM_W:0]   trial;
        logic [TIM_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = dividend[QW+TIM_W-1:QW];
            assign work_in = dividend[QW-1:0];
            assign div_in  = divisor;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign work_in = work_reg[k-1];
            assign div_in  = div_reg[k-1];
        end

        // remaining dividend bits leave at the top, quotient bits enter at the bottom
        assign trial = {rem_in, work_in[QW-1]};
        assign diff  = trial - {1'b0, div_in};
        assign ge    = (trial >= {1'b0, div_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[TIM_W-1:0] : trial[TIM_W-1:0];
                work_reg[k] <= {work_in[QW-2:0], ge};
            end
        end

        if (k < QW-1)
        begin : g_div
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    div_reg[k] <= div_in;
                end
            end
        end
    end

    assign quotient = work_reg[QW-1];

endmodule

// ----- design/pcir_back.sv -----
// pcir_back: resolving pipeline, separating velocity, impulse shares, position shares
// depends on pcir_pkg and pcir_div

module pcir_back #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pcir_pkg::TSTEP_W-1:0]       time_step,
    input  logic [3*(W+1)-1:0]                 rel_velocity,
    input  logic [3*(W+1)-1:0]                 rel_acceleration,
    input  logic [3*pcir_pkg::NORM_W-1:0]      normal_vec,
    input  logic [pcir_pkg::REST_W-1:0]        restitution,
    input  logic [pcir_pkg::IMASS_W-1:0]       main_inverse_mass,
    input  logic [pcir_pkg::IMASS_W-1:0]       other_mass,
    input  logic [pcir_pkg::TIM_W-1:0]         total_mass,
    input  logic [pcir_pkg::PEN_MAG_W-1:0]     pen_mag,
    input  pcir_pkg::pcir_flags_t              flags,
    input  logic [3*W-1:0]                     main_velocity,
    input  logic [3*W-1:0]                     other_velocity,
    input  logic [3*W-1:0]                     main_position,
    input  logic [3*W-1:0]                     other_position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3*W-1:0]                     main_velocity_out,
    output logic [3*W-1:0]                     other_velocity_out,
    output logic [3*W-1:0]                     main_position_out,
    output logic [3*W-1:0]                     other_position_out,
    output logic                               velocity_applied,
    output logic                               position_applied
);
    import pcir_pkg::*;

    localparam int DW    = W + 1;
    localparam int PW    = DW + NORM_W;
    localparam int SW    = PW + 2;
    localparam int SVW   = SW - SV_SHIFT;
    localparam int NSW   = SVW + 1 + REST_W + 1;
    localparam int NSSW  = NSW - REST_SHIFT;
    localparam int LPW   = SW + TSTEP_W + 1;
    localparam int LW    = LPW - ACC_SHIFT;
    localparam int TW    = LW + REST_W + 1;
    localparam int SUMW  = NSSW + 1;
    localparam int QW    = SW - 2;
    localparam int DIVW  = QW + TIM_W;
    localparam int MW    = QW + 1 + NORM_W + 1;
    localparam int PSH   = POS_BASE - F;
    localparam int LAST  = QW + 8;
    localparam int PPW   = PEN_MAG_W + IMASS_W;

    localparam logic signed [MW:0] SAT_HI = (MW+1)'(2**(W-1) - 1);
    localparam logic signed [MW:0] SAT_LO = -SAT_HI - (MW+1)'(1);

    typedef struct packed {
        logic [3*W-1:0]      mv;
        logic [3*W-1:0]      ov;
        logic [3*W-1:0]      mp;
        logic [3*W-1:0]      op;
        logic [3*NORM_W-1:0] normal;
        pcir_flags_t         flags;
        logic                vel_go;
    } side_t;

    typedef struct packed {
        logic [3*DW-1:0]      rv;
        logic [3*DW-1:0]      ra;
        logic [REST_W-1:0]    rest;
        logic [IMASS_W-1:0]   imm;
        logic [IMASS_W-1:0]   imo;
        logic [TIM_W-1:0]     tim;
        logic [PEN_MAG_W-1:0] pen;
    } early_t;

    function automatic logic [W-1:0] sat(input logic signed [MW:0] x);
        logic [W-1:0] r;
        if (x > SAT_HI)
        begin
            r = SAT_HI[W-1:0];
        end
        else if (x < SAT_LO)
        begin
            r = SAT_LO[W-1:0];
        end
        else
        begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    logic   adv;
    logic   v_reg [LAST+1];
    side_t  side_reg [LAST];
    early_t early_reg [6];

    logic signed [PW-1:0]   pv_reg [3];
    logic signed [PW-1:0]   pa_reg [3];
    logic signed [SW-1:0]   svf_reg, lff_reg;
    logic signed [SVW-1:0]  sv3_reg, sv4_reg;
    logic signed [NSW-1:0]  ns0_reg;
    logic signed [LPW-1:0]  lfp_reg;
    logic signed [NSSW-1:0] ns0s_reg;
    logic                   lneg_reg;
    logic signed [TW-1:0]   t_reg;
    logic [QW-1:0]          dv_reg;
    logic [DIVW-1:0]        vdm_reg, vdo_reg, pdm_reg, pdo_reg;
    logic [TIM_W-1:0]       tim_reg;
    logic signed [MW-1:0]   vmp_reg [3];
    logic signed [MW-1:0]   vop_reg [3];
    logic signed [MW-1:0]   pmp_reg [3];
    logic signed [MW-1:0]   pop_reg [3];
    logic [3*W-1:0]         mvo_reg, ovo_reg, mpo_reg, opo_reg;
    logic                   vapp_reg, papp_reg;

    logic signed [SVW-1:0]  sv_c;
    logic signed [SVW:0]    neg_sv;
    logic                   appr;
    logic signed [SUMW-1:0] ns_sum;
    logic signed [SUMW-1:0] ns_c;
    logic signed [SUMW:0]   dv_full;
    logic [QW+IMASS_W-1:0]  vprod_m, vprod_o;
    logic [PPW-1:0]         pprod_m, pprod_o;
    logic [QW-1:0]          km, ko, mm, mo;
    side_t                  s_in;
    side_t                  s_mid;
    early_t                 e_in;
    side_t                  s_fin;
    logic [3*W-1:0]         mvo_next, ovo_next, mpo_next, opo_next;
    logic                   pos_go;

    assign adv       = !v_reg[LAST] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[LAST];

    assign s_in.mv     = main_velocity;
    assign s_in.ov     = other_velocity;
    assign s_in.mp     = main_position;
    assign s_in.op     = other_position;
    assign s_in.normal = normal_vec;
    assign s_in.flags  = flags;
    assign s_in.vel_go = 1'b0;

    assign e_in.rv   = rel_velocity;
    assign e_in.ra   = rel_acceleration;
    assign e_in.rest = restitution;
    assign e_in.imm  = main_inverse_mass;
    assign e_in.imo  = other_mass;
    assign e_in.tim  = total_mass;
    assign e_in.pen  = pen_mag;

    // separating velocity from the dot product, impulse runs when not separating and the total inverse mass is nonzero
    assign sv_c   = $signed(svf_reg[SW-1:SV_SHIFT]);
    assign neg_sv = -((SVW+1)'(sv_c));
    assign appr   = (svf_reg[SW-1] || (svf_reg == '0)) && side_reg[2].flags.mass_nz;

    // side data entering stage three carries the impulse decision
    always_comb
    begin
        s_mid        = side_reg[2];
        s_mid.vel_go = appr;
    end

    // resting contact correction, clamped at zero
    always_comb
    begin
        ns_sum = SUMW'(ns0s_reg) + SUMW'($signed(t_reg[TW-1:REST_SHIFT]));
        ns_c   = SUMW'(ns0s_reg);
        if (lneg_reg)
        begin
            ns_c = ns_sum[SUMW-1] ? '0 : ns_sum;
        end
        dv_full = (SUMW+1)'(ns_c) - (SUMW+1)'(sv4_reg);
    end

    assign vprod_m = {{IMASS_W{1'b0}}, dv_reg} * {{QW{1'b0}}, early_reg[5].imm};
    assign vprod_o = {{IMASS_W{1'b0}}, dv_reg} * {{QW{1'b0}}, early_reg[5].imo};
    assign pprod_m = {{IMASS_W{1'b0}}, early_reg[5].pen} * {{PEN_MAG_W{1'b0}}, early_reg[5].imm};
    assign pprod_o = {{IMASS_W{1'b0}}, early_reg[5].pen} * {{PEN_MAG_W{1'b0}}, early_reg[5].imo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]  <= s_in;
            early_reg[0] <= e_in;
            for (int k = 1; k < LAST; k++)
            begin
                if (k == 3)
                begin
                    side_reg[k] <= s_mid;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
            for (int k = 1; k < 6; k++)
            begin
                early_reg[k] <= early_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                pv_reg[i] <= PW'($signed(early_reg[0].rv[i*DW +: DW]))
                             * PW'($signed(side_reg[0].normal[i*NORM_W +: NORM_W]));
                pa_reg[i] <= PW'($signed(early_reg[0].ra[i*DW +: DW]))
                             * PW'($signed(side_reg[0].normal[i*NORM_W +: NORM_W]));
            end

            svf_reg <= SW'(pv_reg[0]) + SW'(pv_reg[1]) + SW'(pv_reg[2]);
            lff_reg <= SW'(pa_reg[0]) + SW'(pa_reg[1]) + SW'(pa_reg[2]);

            sv3_reg <= sv_c;
            ns0_reg <= NSW'(neg_sv) * NSW'($signed({1'b0, early_reg[2].rest}));
            lfp_reg <= LPW'(lff_reg) * LPW'($signed({1'b0, time_step}));

            sv4_reg  <= sv3_reg;
            ns0s_reg <= $signed(ns0_reg[NSW-1:REST_SHIFT]);
            lneg_reg <= lfp_reg[LPW-1];
            t_reg    <= TW'($signed(lfp_reg[LPW-1:ACC_SHIFT]))
                        * TW'($signed({1'b0, early_reg[3].rest}));

            dv_reg <= dv_full[QW-1:0];

            vdm_reg <= {1'b0, vprod_m};
            vdo_reg <= {1'b0, vprod_o};
            pdm_reg <= DIVW'({pprod_m, 8'd0});
            pdo_reg <= DIVW'({pprod_o, 8'd0});
            tim_reg <= early_reg[5].tim;

            for (int i = 0; i < 3; i++)
            begin
                vmp_reg[i] <= MW'($signed({1'b0, km}))
                              * MW'($signed({side_reg[6+QW].normal[i*NORM_W+NORM_W-1],
                                             side_reg[6+QW].normal[i*NORM_W +: NORM_W]}));
                vop_reg[i] <= MW'($signed({1'b0, ko}))
                              * (-MW'($signed({side_reg[6+QW].normal[i*NORM_W+NORM_W-1],
                                               side_reg[6+QW].normal[i*NORM_W +: NORM_W]})));
                pmp_reg[i] <= MW'($signed({1'b0, mm}))
                              * MW'($signed({side_reg[6+QW].normal[i*NORM_W+NORM_W-1],
                                             side_reg[6+QW].normal[i*NORM_W +: NORM_W]}));
                pop_reg[i] <= MW'($signed({1'b0, mo}))
                              * (-MW'($signed({side_reg[6+QW].normal[i*NORM_W+NORM_W-1],
                                               side_reg[6+QW].normal[i*NORM_W +: NORM_W]})));
            end

            mvo_reg  <= mvo_next;
            ovo_reg  <= ovo_next;
            mpo_reg  <= mpo_next;
            opo_reg  <= opo_next;
            vapp_reg <= s_fin.vel_go;
            papp_reg <= pos_go;
        end
    end

    pcir_div #(.QW(QW)) u_div_vm
    (
        .clk      (clk),
        .en       (adv),
        .dividend (vdm_reg),
        .divisor  (tim_reg),
        .quotient (km)
    );

    pcir_div #(.QW(QW)) u_div_vo
    (
        .clk      (clk),
        .en       (adv),
        .dividend (vdo_reg),
        .divisor  (tim_reg),
        .quotient (ko)
    );

    pcir_div #(.QW(QW)) u_div_pm
    (
        .clk      (clk),
        .en       (adv),
        .dividend (pdm_reg),
        .divisor  (tim_reg),
        .quotient (mm)
    );

    pcir_div #(.QW(QW)) u_div_po
    (
        .clk      (clk),
        .en       (adv),
        .dividend (pdo_reg),
        .divisor  (tim_reg),
        .quotient (mo)
    );

    // apply shares, saturate, keep untouched components as they came
    assign s_fin  = side_reg[LAST-1];
    assign pos_go = s_fin.flags.mass_nz && s_fin.flags.pen_pos;

    always_comb
    begin
        logic signed [MW:0] s_vm, s_vo, s_pm, s_po;
        logic [W-1:0]       c_vm, c_vo, c_pm, c_po;
        for (int i = 0; i < 3; i++)
        begin
            c_vm = s_fin.mv[i*W +: W];
            c_vo = s_fin.ov[i*W +: W];
            c_pm = s_fin.mp[i*W +: W];
            c_po = s_fin.op[i*W +: W];
            s_vm = ($signed({vmp_reg[i][MW-1], vmp_reg[i]}) >>> VEL_SHIFT)
                   + $signed({{(MW+1-W){c_vm[W-1]}}, c_vm});
            s_vo = ($signed({vop_reg[i][MW-1], vop_reg[i]}) >>> VEL_SHIFT)
                   + $signed({{(MW+1-W){c_vo[W-1]}}, c_vo});
            s_pm = ($signed({pmp_reg[i][MW-1], pmp_reg[i]}) >>> PSH)
                   + $signed({{(MW+1-W){c_pm[W-1]}}, c_pm});
            s_po = ($signed({pop_reg[i][MW-1], pop_reg[i]}) >>> PSH)
                   + $signed({{(MW+1-W){c_po[W-1]}}, c_po});
            mvo_next[i*W +: W] = s_fin.vel_go ? sat(s_vm) : c_vm;
            ovo_next[i*W +: W] = (s_fin.vel_go && s_fin.flags.has_other) ? sat(s_vo) : c_vo;
            mpo_next[i*W +: W] = pos_go ? sat(s_pm) : c_pm;
            opo_next[i*W +: W] = (pos_go && s_fin.flags.has_other) ? sat(s_po) : c_po;
        end
    end

    assign main_velocity_out  = mvo_reg;
    assign other_velocity_out = ovo_reg;
    assign main_position_out  = mpo_reg;
    assign other_position_out = opo_reg;
    assign velocity_applied   = vapp_reg;
    assign position_applied   = papp_reg;

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for particle_contact_impulse_resolve_core
// depends on the core, its package pcir_pkg and the modules below it
// contacts go in on the s_ stream and results are checked against a built-in predictor

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcir_pkg::*;

    localparam int CW        = 16;
    localparam int FB        = 8;
    localparam int IN_W      = 400;
    localparam int OUT_W     = 192;
    localparam int DRAIN_CYC = 120;    // long enough for the pipeline to drain
    localparam int WD_LIMIT  = 20000;  // cycles with no transaction while work is pending

    localparam logic [2:0] ADDR_TIME_STEP = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    typedef struct {
        logic [47:0] vel_main;
        logic [47:0] vel_other;
        logic [47:0] acc_main;
        logic [47:0] acc_other;
        logic [47:0] pos_main;
        logic [47:0] pos_other;
        logic [15:0] imass_main;
        logic [15:0] imass_other;
        logic [47:0] normal;
        logic [15:0] pen;
        logic [8:0]  rest;
        logic        has_other;
    } contact_t;

    typedef struct {
        logic [47:0] vel_main;
        logic [47:0] vel_other;
        logic [47:0] pos_main;
        logic [47:0] pos_other;
        logic        vel_applied;
        logic        pos_applied;
    } resolved_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of the time_step register
    logic [15:0] frame_time;
    resolved_t   resolved_q[$];
    int          mismatch_count;
    int          contacts_sent;
    int          results_seen;
    int          vel_hits;
    int          pos_hits;
    int          idle_cycles;
    bit          no_gaps;       // when set, the sender inserts no idle gaps and result-side stalls are not extended

    particle_contact_impulse_resolve_core #(
        .COMPONENT_WIDTH(CW),
        .FRACTION_BITS  (FB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------

    function automatic longint comp_of(logic [47:0] word, int idx);
        logic signed [15:0] c;
        c = word[16*idx +: 16];
        return longint'(c);
    endfunction

    function automatic logic [15:0] clamp_comp(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            x = hi;
        else if (x < lo)
            x = lo;
        return x[15:0];
    endfunction

    function automatic resolved_t resolve_contact(contact_t c, logic [15:0] ts);
        resolved_t r;
        longint    n[3];
        longint    rel_v;
        longint    rel_a;
        longint    sep;
        longint    new_sep;
        longint    acc_ts;
        longint    dv;
        longint    share_m;
        longint    share_o;
        longint    im_m;
        longint    im_o;
        longint    im_sum;
        longint    pen;
        longint    rest;
        longint    v;
        r.vel_main    = c.vel_main;
        r.vel_other   = c.vel_other;
        r.pos_main    = c.pos_main;
        r.pos_other   = c.pos_other;
        r.vel_applied = 1'b0;
        r.pos_applied = 1'b0;
        im_m   = longint'(c.imass_main);
        im_o   = c.has_other ? longint'(c.imass_other) : 0;
        im_sum = im_m + im_o;
        pen    = longint'($signed(c.pen));
        rest   = longint'(c.rest);
        for (int i = 0; i < 3; i++)
            n[i] = comp_of(c.normal, i);
        if (im_sum > 0)
        begin
            rel_v = 0;
            rel_a = 0;
            for (int i = 0; i < 3; i++)
            begin
                rel_v += (comp_of(c.vel_main, i) - (c.has_other ? comp_of(c.vel_other, i) : 0))
                         * n[i];
                rel_a += (comp_of(c.acc_main, i) - (c.has_other ? comp_of(c.acc_other, i) : 0))
                         * n[i];
            end
            // approaching or resting: bounce plus rest-contact correction
            if (rel_v <= 0)
            begin
                sep     = rel_v >>> SV_SHIFT;
                new_sep = (-sep * rest) >>> REST_SHIFT;
                acc_ts  = rel_a * longint'(ts);
                if (acc_ts < 0)
                begin
                    new_sep += (rest * (acc_ts >>> ACC_SHIFT)) >>> REST_SHIFT;
                    if (new_sep < 0)
                        new_sep = 0;
                end
                dv      = new_sep - sep;
                share_m = (dv * im_m) / im_sum;
                share_o = (dv * im_o) / im_sum;
                for (int i = 0; i < 3; i++)
                begin
                    v = comp_of(c.vel_main, i) + ((share_m * n[i]) >>> VEL_SHIFT);
                    r.vel_main[16*i +: 16] = clamp_comp(v);
                    if (c.has_other)
                    begin
                        v = comp_of(c.vel_other, i) + ((-(share_o * n[i])) >>> VEL_SHIFT);
                        r.vel_other[16*i +: 16] = clamp_comp(v);
                    end
                end
                r.vel_applied = 1'b1;
            end
            // push apart along the normal
            if (pen > 0)
            begin
                share_m = (pen * im_m * 256) / im_sum;
                share_o = (pen * im_o * 256) / im_sum;
                for (int i = 0; i < 3; i++)
                begin
                    v = comp_of(c.pos_main, i) + ((share_m * n[i]) >>> (POS_BASE - FB));
                    r.pos_main[16*i +: 16] = clamp_comp(v);
                    if (c.has_other)
                    begin
                        v = comp_of(c.pos_other, i) + ((-(share_o * n[i])) >>> (POS_BASE - FB));
                        r.pos_other[16*i +: 16] = clamp_comp(v);
                    end
                end
                r.pos_applied = 1'b1;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // idle gaps: mostly none or short, occasionally long
    // ---------------------------------------------------------------

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // result side: random stalls on m_tready, checker on each transaction
    // ---------------------------------------------------------------

    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= idle_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        $display("MISMATCH result %0d %s: want %h got %h", results_seen, what, want, got);
    endtask

    always @(posedge clk)
    begin
        resolved_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (resolved_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", 64'd0, m_tdata[63:0]);
            end
            else
            begin
                want = resolved_q.pop_front();
                if (m_tdata[47:0] !== want.vel_main)
                    report_mismatch("main_velocity_out", want.vel_main, m_tdata[47:0]);
                if (m_tdata[95:48] !== want.vel_other)
                    report_mismatch("other_velocity_out", want.vel_other, m_tdata[95:48]);
                if (m_tdata[143:96] !== want.pos_main)
                    report_mismatch("main_position_out", want.pos_main, m_tdata[143:96]);
                if (m_tdata[191:144] !== want.pos_other)
                    report_mismatch("other_position_out", want.pos_other, m_tdata[191:144]);
                if (m_tuser[0] !== want.vel_applied)
                    report_mismatch("velocity_applied", want.vel_applied, m_tuser[0]);
                if (m_tuser[1] !== want.pos_applied)
                    report_mismatch("position_applied", want.pos_applied, m_tuser[1]);
                vel_hits += want.vel_applied;
                pos_hits += want.pos_applied;
            end
            results_seen++;
        end
    end

    // watchdog: no transaction for too long while something is outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && resolved_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", resolved_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // contact sender and register access
    // ---------------------------------------------------------------

    task automatic send_contact(contact_t c);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, c.rest, c.pen, c.normal, c.imass_other, c.imass_main,
                     c.pos_other, c.pos_main, c.acc_other, c.acc_main,
                     c.vel_other, c.vel_main};
        s_tuser  <= c.has_other;
        do
            @(posedge clk);
        while (!s_tready);
        resolved_q.push_back(resolve_contact(c, frame_time));
        contacts_sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // returns once every outstanding result is back and the pipe has drained
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (resolved_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TIME_STEP)
            frame_time = value[15:0];
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------

    function automatic logic [47:0] rand_vec(bit full);
        logic [47:0] w;
        for (int i = 0; i < 3; i++)
            w[16*i +: 16] = full ? 16'($urandom) : 16'($urandom_range(0, 4095) - 2048);
        return w;
    endfunction

    function automatic logic [47:0] rand_normal();
        logic [47:0] w;
        int          axis;
        int          roll;
        roll = $urandom_range(0, 3);
        w    = '0;
        if (roll < 2)
        begin
            // unit normal along one axis
            axis = $urandom_range(0, 2);
            w[16*axis +: 16] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
        else if (roll == 2)
        begin
            // diagonal normals of about unit length
            for (int i = 0; i < 2; i++)
                w[16*i +: 16] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
        end
        else
        begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        bit       full;
        full          = ($urandom_range(0, 3) == 0);
        c.vel_main    = rand_vec(full);
        c.vel_other   = rand_vec(full);
        c.acc_main    = rand_vec(full);
        c.acc_other   = rand_vec(full);
        c.pos_main    = rand_vec(full);
        c.pos_other   = rand_vec(full);
        c.imass_main  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        c.imass_other = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        c.normal      = rand_normal();
        c.pen         = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2047) - 256);
        c.rest        = 9'($urandom_range(0, 511));
        c.has_other   = ($urandom_range(0, 9) < 7);
        return c;
    endfunction

    // a plain head-on contact along +x, other particle moving into main
    function automatic contact_t base_contact();
        contact_t c;
        c.vel_main    = {16'sd0, 16'sd0, -16'sd512};
        c.vel_other   = {16'sd0, 16'sd0, 16'sd256};
        c.acc_main    = {16'sd0, 16'sd0, -16'sd2560};
        c.acc_other   = '0;
        c.pos_main    = {16'sd0, 16'sd0, 16'sd256};
        c.pos_other   = {16'sd0, 16'sd0, 16'sd512};
        c.imass_main  = 16'd256;
        c.imass_other = 16'd128;
        c.normal      = {16'sd0, 16'sd0, 16'sd16384};
        c.pen         = 16'sd64;
        c.rest        = 9'd128;
        c.has_other   = 1'b1;
        return c;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_reset_time_step();
        contact_t c;
        // resting contact under gravity, relies on the reset value of time_step
        c = base_contact();
        c.vel_main  = '0;
        c.vel_other = '0;
        send_contact(c);
        wait_drained();
    endtask

    task automatic test_directed();
        contact_t c;
        c = base_contact();
        send_contact(c);
        // scenery contact: other fields ignored and passed through
        c.has_other   = 1'b0;
        c.imass_other = 16'hFFFF;
        send_contact(c);
        // zero total inverse mass
        c = base_contact();
        c.imass_main  = 16'd0;
        c.imass_other = 16'd0;
        send_contact(c);
        c.has_other  = 1'b0;
        c.imass_other = 16'd500;
        send_contact(c);
        // immovable main, movable other
        c = base_contact();
        c.imass_main = 16'd0;
        send_contact(c);
        // already separating
        c = base_contact();
        c.vel_main = {16'sd0, 16'sd0, 16'sd512};
        c.vel_other = '0;
        send_contact(c);
        // zero separating velocity still runs the step
        c.vel_main = '0;
        send_contact(c);
        // restitution at 1.0, at its maximum and at zero
        c = base_contact();
        c.rest = 9'd256;
        send_contact(c);
        c.rest = 9'h1FF;
        send_contact(c);
        c.rest = 9'd0;
        send_contact(c);
        // non-unit normals
        c = base_contact();
        c.normal = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_contact(c);
        c.normal = {16'sh8000, 16'sh8000, 16'sh8000};
        send_contact(c);
        c.normal = '0;
        send_contact(c);
        // penetration extremes and zero
        c = base_contact();
        c.pen = 16'sh7FFF;
        send_contact(c);
        c.pen = 16'sh8000;
        send_contact(c);
        c.pen = 16'sd0;
        send_contact(c);
        // saturation with largest masses and velocities
        c = base_contact();
        c.vel_main    = {3{16'sh8000}};
        c.vel_other   = {3{16'sh7FFF}};
        c.acc_main    = {3{16'sh8000}};
        c.acc_other   = {3{16'sh7FFF}};
        c.pos_main    = {3{16'sh7FFF}};
        c.pos_other   = {3{16'sh8000}};
        c.imass_main  = 16'hFFFF;
        c.imass_other = 16'hFFFF;
        c.normal      = {16'sd16384, 16'sd16384, 16'sd16384};
        c.pen         = 16'sh7FFF;
        c.rest        = 9'h1FF;
        send_contact(c);
        c.normal = {-16'sd16384, -16'sd16384, -16'sd16384};
        send_contact(c);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
        begin
            // a back-to-back stretch in every batch
            no_gaps = (k >= count / 3 && k < count / 3 + 40);
            send_contact(rand_contact());
            // sender holds off until every result is back
            if (k == count / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (resolved_q.size() != 0)
                    @(posedge clk);
            end
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        frame_time     = TSTEP_RESET;
        mismatch_count = 0;
        contacts_sent  = 0;
        results_seen   = 0;
        vel_hits       = 0;
        pos_hits       = 0;
        idle_cycles    = 0;
        no_gaps        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_time_step();
        test_directed();
        // unused address must leave time_step alone
        write_reg(ADDR_UNUSED, 32'h0000_0001);
        test_random(300);
        write_reg(ADDR_TIME_STEP, 32'h0000_FFFF);
        test_random(350);
        write_reg(ADDR_TIME_STEP, 32'h0000_0000);
        test_random(350);
        write_reg(ADDR_TIME_STEP, 32'($urandom_range(1, 65534)));
        test_random(350);

        $display("covered %0d contacts, %0d results, %0d velocity and %0d position updates",
                 contacts_sent, results_seen, vel_hits, pos_hits);
        $display("time_step swept through reset value, max, zero and a random setting");
        if (mismatch_count == 0 && resolved_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pcir_pkg.sv
design/pcir_front.sv
design/pcir_fifo.sv
design/pcir_div.sv
design/pcir_back.sv
design/particle_contact_impulse_resolve_core.sv
sim/tb_top.sv
